/* hw/rtl/sfpd_pkg.sv */
package sfpd_pkg;

  // Payload bytes kept for decoding; later payload bytes only feed the checksum
  localparam int StoreBytes = 13;
  localparam int StoreIdxW  = $clog2(StoreBytes);
  localparam int WordCount  = 6;

  // Frame queue between parser and decoder
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgHeader   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSource   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTarget   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFuncLim  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLenLim   = 3'd4;

  // Configuration reset values
  localparam logic [7:0] RstHeader  = 8'hAA;
  localparam logic [7:0] RstSource  = 8'h22;
  localparam logic [7:0] RstTarget  = 8'hAF;
  localparam logic [7:0] RstFuncLim = 8'h56;
  localparam logic [7:0] RstLenLim  = 8'd45;

  // Function codes
  localparam logic [7:0] CodeFlow     = 8'h51;
  localparam logic [7:0] CodeHeight   = 8'h52;
  localparam logic [7:0] CodeInertial = 8'h53;
  localparam logic [7:0] CodeAttitude = 8'h54;

  // Mode byte values
  localparam logic [7:0] ModeRaw   = 8'd0;
  localparam logic [7:0] ModeFused = 8'd1;

  // Frame kinds
  localparam logic [2:0] KindFlowRaw      = 3'd0;
  localparam logic [2:0] KindFlowFused    = 3'd1;
  localparam logic [2:0] KindHeightRaw    = 3'd2;
  localparam logic [2:0] KindHeightFused  = 3'd3;
  localparam logic [2:0] KindInertialRaw  = 3'd4;
  localparam logic [2:0] KindInertialFilt = 3'd5;
  localparam logic [2:0] KindEuler        = 3'd6;
  localparam logic [2:0] KindQuaternion   = 3'd7;

  // Minimum payload lengths per kind
  localparam logic [7:0] NeedFlowRaw   = 8'd5;
  localparam logic [7:0] NeedFlowFused = 8'd11;
  localparam logic [7:0] NeedHeight    = 8'd3;
  localparam logic [7:0] NeedInertial  = 8'd13;
  localparam logic [7:0] NeedEuler     = 8'd7;
  localparam logic [7:0] NeedQuat      = 8'd9;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SRC     = 3'd1,
    PH_TGT     = 3'd2,
    PH_FUNC    = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] source_id;
    logic [7:0] target_id;
    logic [7:0] function_limit;
    logic [7:0] length_limit;
  } cfg_t;

  // A checked frame handed from parser to decoder
  typedef struct packed {
    logic [7:0]                     func;
    logic [7:0]                     count;
    logic [StoreBytes-1:0][7:0]     data;
  } frame_t;

  typedef struct packed {
    logic [2:0]                  kind;
    logic [7:0]                  quality;
    logic [7:0]                  light;
    logic [WordCount-1:0][15:0]  words;
  } result_t;

endpackage

/* hw/rtl/sfpd_front.sv */
module sfpd_front import sfpd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   push_i,
  input  logic   [7:0] byte_in_i,
  output logic   full_o,
  input  logic   q_full_i,
  output logic   q_push_o,
  output frame_t q_frame_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] func_q, func_d;
  logic       store_we;
  logic [StoreBytes-1:0][7:0] store_q;
  logic       acc;

  // Only the checksum byte needs room in the frame queue
  assign full_o = q_full_i && (phase_q == PH_CHECK);
  assign acc    = push_i && !full_o;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      case (phase_q)
        PH_SRC:  phase_d = (byte_in_i == cfg_i.source_id) ? PH_TGT : PH_IDLE;
        PH_TGT:  phase_d = (byte_in_i == cfg_i.target_id) ? PH_FUNC : PH_IDLE;
        PH_FUNC: phase_d = (byte_in_i < cfg_i.function_limit) ? PH_LEN : PH_IDLE;
        PH_LEN: begin
          phase_d = (byte_in_i != 8'd0 && byte_in_i < cfg_i.length_limit) ?
                    PH_PAYLOAD : PH_IDLE;
        end
        PH_PAYLOAD: begin
          if (remain_q != 8'd0) begin
            phase_d = (remain_q == 8'd1) ? PH_CHECK : PH_PAYLOAD;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_CHECK: phase_d = PH_IDLE;
        default:  phase_d = (byte_in_i == cfg_i.header_byte) ? PH_SRC : PH_IDLE;
      endcase
    end
  end

  // Checksum, counters, store writes and frame hand-off
  always_comb begin
    remain_d = remain_q;
    count_d  = count_q;
    sum_d    = sum_q;
    func_d   = func_q;
    store_we = 1'b0;
    q_push_o = 1'b0;
    if (acc) begin
      case (phase_q)
        PH_SRC: begin
          if (byte_in_i == cfg_i.source_id) sum_d = sum_q + byte_in_i;
        end
        PH_TGT: begin
          if (byte_in_i == cfg_i.target_id) sum_d = sum_q + byte_in_i;
        end
        PH_FUNC: begin
          if (byte_in_i < cfg_i.function_limit) begin
            func_d = byte_in_i;
            sum_d  = sum_q + byte_in_i;
          end
        end
        PH_LEN: begin
          if (byte_in_i != 8'd0 && byte_in_i < cfg_i.length_limit) begin
            remain_d = byte_in_i;
            count_d  = 8'd0;
            sum_d    = sum_q + byte_in_i;
          end
        end
        PH_PAYLOAD: begin
          if (remain_q != 8'd0) begin
            store_we = (count_q < 8'(StoreBytes));
            count_d  = count_q + 8'd1;
            remain_d = remain_q - 8'd1;
            sum_d    = sum_q + byte_in_i;
          end
        end
        PH_CHECK: q_push_o = (byte_in_i == sum_q);
        default: begin
          if (byte_in_i == cfg_i.header_byte) sum_d = byte_in_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      remain_q <= 8'd0;
      count_q  <= 8'd0;
      sum_q    <= 8'd0;
      func_q   <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      func_q   <= func_d;
    end
  end

  // Payload store, no reset
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[count_q[StoreIdxW-1:0]] <= byte_in_i;
  end

  assign q_frame_o.func  = func_q;
  assign q_frame_o.count = count_q;
  assign q_frame_o.data  = store_q;

endmodule

/* hw/rtl/sfpd_queue.sv */
module sfpd_queue import sfpd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t frame_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t frame_o
);

  frame_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign frame_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= frame_i;
  end

endmodule

/* hw/rtl/sfpd_back.sv */
module sfpd_back import sfpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  frame_t  q_frame_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t res_o
);

  result_t    res_d, res_q;
  logic       hit;
  logic       take;
  logic       out_valid_q, out_valid_d;
  logic [7:0] mode;
  logic [7:0] len;

  assign mode = q_frame_i.data[0];
  assign len  = q_frame_i.count;

  // Decode the frame at the queue head
  always_comb begin
    res_d = '0;
    hit   = 1'b0;
    case (q_frame_i.func)
      CodeFlow: begin
        if (mode == ModeRaw && len >= NeedFlowRaw) begin
          hit            = 1'b1;
          res_d.kind     = KindFlowRaw;
          res_d.quality  = q_frame_i.data[1];
          res_d.words[0] = {8'h00, q_frame_i.data[2]};
          res_d.words[1] = {8'h00, q_frame_i.data[3]};
          res_d.light    = q_frame_i.data[4];
        end else if (mode == ModeFused && len >= NeedFlowFused) begin
          hit            = 1'b1;
          res_d.kind     = KindFlowFused;
          res_d.quality  = q_frame_i.data[1];
          res_d.light    = q_frame_i.data[10];
          res_d.words[0] = {q_frame_i.data[2], q_frame_i.data[3]};
          res_d.words[1] = {q_frame_i.data[4], q_frame_i.data[5]};
          res_d.words[2] = {q_frame_i.data[6], q_frame_i.data[7]};
          res_d.words[3] = {q_frame_i.data[8], q_frame_i.data[9]};
        end
      end
      CodeHeight: begin
        if ((mode == ModeRaw || mode == ModeFused) && len >= NeedHeight) begin
          hit            = 1'b1;
          res_d.kind     = (mode == ModeFused) ? KindHeightFused : KindHeightRaw;
          res_d.words[0] = {q_frame_i.data[1], q_frame_i.data[2]};
        end
      end
      CodeInertial: begin
        if ((mode == ModeRaw || mode == ModeFused) && len >= NeedInertial) begin
          hit            = 1'b1;
          res_d.kind     = (mode == ModeFused) ? KindInertialFilt : KindInertialRaw;
          res_d.words[0] = {q_frame_i.data[1], q_frame_i.data[2]};
          res_d.words[1] = {q_frame_i.data[3], q_frame_i.data[4]};
          res_d.words[2] = {q_frame_i.data[5], q_frame_i.data[6]};
          res_d.words[3] = {q_frame_i.data[7], q_frame_i.data[8]};
          res_d.words[4] = {q_frame_i.data[9], q_frame_i.data[10]};
          res_d.words[5] = {q_frame_i.data[11], q_frame_i.data[12]};
        end
      end
      CodeAttitude: begin
        if (mode == ModeRaw && len >= NeedEuler) begin
          hit            = 1'b1;
          res_d.kind     = KindEuler;
          res_d.words[0] = {q_frame_i.data[1], q_frame_i.data[2]};
          res_d.words[1] = {q_frame_i.data[3], q_frame_i.data[4]};
          res_d.words[2] = {q_frame_i.data[5], q_frame_i.data[6]};
        end else if (mode == ModeFused && len >= NeedQuat) begin
          hit            = 1'b1;
          res_d.kind     = KindQuaternion;
          res_d.words[0] = {q_frame_i.data[1], q_frame_i.data[2]};
          res_d.words[1] = {q_frame_i.data[3], q_frame_i.data[4]};
          res_d.words[2] = {q_frame_i.data[5], q_frame_i.data[6]};
          res_d.words[3] = {q_frame_i.data[7], q_frame_i.data[8]};
        end
      end
      default: hit = 1'b0;
    endcase
  end

  // Output register: refill while it is empty or the current request is taken
  assign take        = q_valid_i && (!out_valid_q || pop_i);
  assign q_pop_o     = take;
  assign out_valid_d = (take && hit) || (out_valid_q && !pop_i);
  assign empty_o     = !out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && hit) res_q <= res_d;
  end

endmodule

/* hw/rtl/sensor_frame_parser_decoder.sv */
// Frame parser and decoder for an optical-flow sensor byte stream. One byte is
// taken per clock through push_i/full_o; the parser tracks header, IDs,
// function code, length, payload and additive checksum, and a byte that does
// not fit the current field drops the frame. A frame with a good checksum
// passes through a two-entry frame queue to the decoder, which writes one
// request into the output register when the function code, mode byte and
// length give a known kind. full_o rises only on the checksum byte while the
// frame queue holds two frames; otherwise a byte is taken every cycle. A
// result is written into the frame queue when its checksum byte is taken and
// into the output register once that is free, not while earlier results wait
// for pop_i. Registers written through cfg_we_i take effect on the next byte.
module sensor_frame_parser_decoder import sfpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic [7:0]          byte_in_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [2:0]          frame_kind_o,
  output logic [7:0]          quality_o,
  output logic [7:0]          light_o,
  output logic [15:0]         word0_o,
  output logic [15:0]         word1_o,
  output logic [15:0]         word2_o,
  output logic [15:0]         word3_o,
  output logic [15:0]         word4_o,
  output logic [15:0]         word5_o
);

  cfg_t    cfg_q;
  logic    q_full, q_push, q_valid, q_pop;
  frame_t  q_in, q_out;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte    <= RstHeader;
      cfg_q.source_id      <= RstSource;
      cfg_q.target_id      <= RstTarget;
      cfg_q.function_limit <= RstFuncLim;
      cfg_q.length_limit   <= RstLenLim;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeader:  cfg_q.header_byte    <= cfg_wdata_i;
        CfgSource:  cfg_q.source_id      <= cfg_wdata_i;
        CfgTarget:  cfg_q.target_id      <= cfg_wdata_i;
        CfgFuncLim: cfg_q.function_limit <= cfg_wdata_i;
        CfgLenLim:  cfg_q.length_limit   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sfpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push_i),
    .byte_in_i (byte_in_i),
    .full_o    (full_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_frame_o (q_in)
  );

  sfpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .frame_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .frame_o (q_out)
  );

  sfpd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_frame_i (q_out),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .res_o     (res)
  );

  assign frame_kind_o = res.kind;
  assign quality_o    = res.quality;
  assign light_o      = res.light;
  assign word0_o      = res.words[0];
  assign word1_o      = res.words[1];
  assign word2_o      = res.words[2];
  assign word3_o      = res.words[3];
  assign word4_o      = res.words[4];
  assign word5_o      = res.words[5];

endmodule
